// ===== rtl/aams_pkg.sv =====
// ----------------------------------------------------------------------------
// aams_pkg
// Shared types, constants and helpers of the area-averaging mask resampler.
// ----------------------------------------------------------------------------
`default_nettype none
package aams_pkg;

   localparam int MAX_SRC_PIXELS = 262144;
   localparam int MAX_DIM        = 4096;
   localparam int ADDR_W         = $clog2(MAX_SRC_PIXELS);
   localparam int DIM_W          = 13;
   localparam int XY_W           = 12;
   localparam int VAL_W          = 16;
   localparam int COORD_W        = 2 * DIM_W;
   localparam int NUM_W          = 35;
   localparam int DEN_W          = ADDR_W + 1;
   localparam int CNT_W          = 6;
   localparam int ONE_Q15        = 32768;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_DST_WIDTH  = 3'd2,
      REG_DST_HEIGHT = 3'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_SAMPLE = 2'd1,
      ERR_RANGE  = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SETUP,
      ST_ROW,
      ST_READ,
      ST_WEIGHT,
      ST_ACCUM,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      SEL_XLO,
      SEL_XHI,
      SEL_YLO,
      SEL_YHI,
      SEL_OUT
   } div_sel_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

   function automatic logic [DIM_W-1:0] overlap(input logic [COORD_W-1:0] a0,
                                                input logic [COORD_W-1:0] a1,
                                                input logic [COORD_W-1:0] b0,
                                                input logic [COORD_W-1:0] b1);
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [COORD_W-1:0] diff;
      lo   = (a0 > b0) ? a0 : b0;
      hi   = (a1 < b1) ? a1 : b1;
      diff = hi - lo;
      return (hi > lo) ? diff[DIM_W-1:0] : '0;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/aams_store.sv =====
// ----------------------------------------------------------------------------
// aams_store
// Source sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module aams_store (
   input  wire logic                          clock,
   input  wire aams_pkg::store_wr_type        wr,
   input  wire aams_pkg::store_rd_type        rd,
   output logic [aams_pkg::VAL_W-1:0]         rd_data
);
   import aams_pkg::*;

   logic [VAL_W-1:0] mem [MAX_SRC_PIXELS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/aams_div.sv =====
// ----------------------------------------------------------------------------
// aams_div
// Restoring divider, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
`default_nettype none
module aams_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire aams_pkg::div_req_type req,
   output aams_pkg::div_rsp_type      rsp
);
   import aams_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   always_comb begin
      shifted = {r_ff, q_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         q_in    = req.numer;
         r_in    = '0;
         d_in    = req.denom;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            r_in = diff[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = shifted[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule
`default_nettype wire

// ===== rtl/area_average_mask_resample.sv =====
// ----------------------------------------------------------------------------
// area_average_mask_resample
// Resamples a stored Q1.15 coverage mask to a target grid by area averaging.
//
// The req_ channel carries one item per transfer. A load (action 0) writes
// one sample into the source memory and gives no result. A compute (action 1)
// names one target pixel and gives exactly one rsp_ transfer with the
// averaged value and an error code.
// A compute runs a size and coordinate check, four footprint divisions,
// a read-multiply-accumulate walk over the covered source samples row by
// row, and a final rounding division, which is skipped if a sample exceeds
// 1.0. All divisions use the shared bit-serial divider; a range error skips
// the divisions and the walk.
// The csr_ channel writes the four size registers; it is always ready.
// The result is held in an output register: the next item is taken while it
// waits, and only a later result waits for rsp_ready.
// Reset sets all sizes to 1, drops any pending result and idles the
// sequencer; the source memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module area_average_mask_resample (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [aams_pkg::ADDR_W-1:0]   req_sample_index,
   input  wire logic [aams_pkg::VAL_W-1:0]    req_sample_value,
   input  wire logic [aams_pkg::XY_W-1:0]     req_out_x,
   input  wire logic [aams_pkg::XY_W-1:0]     req_out_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [aams_pkg::VAL_W-1:0]         rsp_pixel_value,
   output logic [1:0]                         rsp_error_code,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [aams_pkg::DIM_W-1:0]    csr_data
);
   import aams_pkg::*;

   state_type   state_ff, state_in;
   div_sel_type sel_ff;

   logic [DIM_W-1:0]   sw_ff, sh_ff, dw_ff, dh_ff;
   logic [XY_W-1:0]    ox_ff, oy_ff;
   logic [COORD_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [DEN_W-1:0]   area_ff;
   logic [DIM_W-1:0]   sx_lo_ff, sx_hi_ff, sy_hi_ff, sx_ff, sy_ff;
   logic [COORD_W-1:0] xs0_ff, xs_ff, ys_ff;
   logic [ADDR_W-1:0]  row_ff;
   logic [DIM_W-1:0]   wx_ff, wy_ff;
   logic [COORD_W-1:0] w_ff;
   logic [NUM_W-1:0]   total_ff;
   logic               bad_ff;
   logic [VAL_W-1:0]   pix_ff;
   err_type            err_ff;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_pix_ff;
   logic [1:0]         rsp_err_ff;

   logic               req_fire, out_free;
   logic               dims_ok, range_bad;
   logic [COORD_W-1:0] area_full, x0_c, y0_c;
   logic [COORD_W-1:0] row_full, ys_c, xs0_c;
   logic [2*VAL_W+DIM_W-3:0] prod;
   logic               sample_bad, last_x, last_y;
   logic [DIM_W-1:0]   sx_next, sy_next;
   logic [DIM_W-1:0]   xhi_c, yhi_c;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   store_wr_type st_wr;
   store_rd_type st_rd;
   logic [VAL_W-1:0] rd_data;

   aams_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd      (st_rd),
      .rd_data (rd_data)
   );

   aams_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dims_ok = (sw_ff != '0) && (sw_ff <= DIM_W'(MAX_DIM)) &&
                (sh_ff != '0) && (sh_ff <= DIM_W'(MAX_DIM)) &&
                (dw_ff != '0) && (dw_ff <= DIM_W'(MAX_DIM)) &&
                (dh_ff != '0) && (dh_ff <= DIM_W'(MAX_DIM));
      area_full = {{DIM_W{1'b0}}, sw_ff} * {{DIM_W{1'b0}}, sh_ff};
      x0_c = {{(COORD_W-XY_W){1'b0}}, ox_ff} * {{DIM_W{1'b0}}, sw_ff};
      y0_c = {{(COORD_W-XY_W){1'b0}}, oy_ff} * {{DIM_W{1'b0}}, sh_ff};
      range_bad = !dims_ok || (area_full > COORD_W'(MAX_SRC_PIXELS)) ||
                  ({1'b0, ox_ff} >= dw_ff) || ({1'b0, oy_ff} >= dh_ff);
      ys_c     = {{DIM_W{1'b0}}, sy_ff} * {{DIM_W{1'b0}}, dh_ff};
      row_full = {{DIM_W{1'b0}}, sy_ff} * {{DIM_W{1'b0}}, sw_ff};
      xs0_c    = {{DIM_W{1'b0}}, sx_lo_ff} * {{DIM_W{1'b0}}, dw_ff};
      prod = {{(DIM_W-3){1'b0}}, rd_data} * {{(2*VAL_W-COORD_W-3+DIM_W-DIM_W){1'b0}}, w_ff};
      sample_bad = rd_data > VAL_W'(ONE_Q15);
      sx_next = sx_ff + DIM_W'(1);
      sy_next = sy_ff + DIM_W'(1);
      last_x  = sx_next >= sx_hi_ff;
      last_y  = sy_next >= sy_hi_ff;
      xhi_c = (div_rsp.quot > NUM_W'(sw_ff)) ? sw_ff : div_rsp.quot[DIM_W-1:0];
      yhi_c = (div_rsp.quot > NUM_W'(sh_ff)) ? sh_ff : div_rsp.quot[DIM_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_action) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:     state_in = range_bad ? ST_DONE : ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (sel_ff)
                  SEL_YHI: state_in = ST_SETUP;
                  SEL_OUT: state_in = ST_DONE;
                  default: state_in = ST_DIV_START;
               endcase
            end
         end
         ST_SETUP:  state_in = ST_ROW;
         ST_ROW:    state_in = ST_READ;
         ST_READ:   state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_ACCUM;
         ST_ACCUM: begin
            priority if (!last_x) begin
               state_in = ST_READ;
            end else if (!last_y) begin
               state_in = ST_ROW;
            end else if (bad_ff || sample_bad) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      csr_ready     = 1'b1;
      st_wr.en      = req_fire && !req_action;
      st_wr.addr    = req_sample_index;
      st_wr.data    = req_sample_value;
      st_rd.en      = (state_ff == ST_READ);
      st_rd.addr    = row_ff + ADDR_W'(sx_ff);
      div_req.start = (state_ff == ST_DIV_START);
      unique case (sel_ff)
         SEL_XLO: begin
            div_req.numer = NUM_W'(x0_ff);
            div_req.denom = DEN_W'(dw_ff);
         end
         SEL_XHI: begin
            div_req.numer = NUM_W'(x1_ff) + NUM_W'(dw_ff) - NUM_W'(1);
            div_req.denom = DEN_W'(dw_ff);
         end
         SEL_YLO: begin
            div_req.numer = NUM_W'(y0_ff);
            div_req.denom = DEN_W'(dh_ff);
         end
         SEL_YHI: begin
            div_req.numer = NUM_W'(y1_ff) + NUM_W'(dh_ff) - NUM_W'(1);
            div_req.denom = DEN_W'(dh_ff);
         end
         default: begin
            div_req.numer = total_ff + NUM_W'(area_ff >> 1);
            div_req.denom = area_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_XLO;
         sw_ff        <= DIM_W'(1);
         sh_ff        <= DIM_W'(1);
         dw_ff        <= DIM_W'(1);
         dh_ff        <= DIM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            priority case (csr_index)
               REG_SRC_WIDTH:  sw_ff <= csr_data;
               REG_SRC_HEIGHT: sh_ff <= csr_data;
               REG_DST_WIDTH:  dw_ff <= csr_data;
               REG_DST_HEIGHT: dh_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_CHECK) begin
            sel_ff <= SEL_XLO;
         end else if (state_ff == ST_ACCUM) begin
            sel_ff <= SEL_OUT;
         end else if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
            unique case (sel_ff)
               SEL_XLO: sel_ff <= SEL_XHI;
               SEL_XHI: sel_ff <= SEL_YLO;
               SEL_YLO: sel_ff <= SEL_YHI;
               default: sel_ff <= sel_ff;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ox_ff <= req_out_x;
         oy_ff <= req_out_y;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_pix_ff <= pix_ff;
         rsp_err_ff <= err_ff;
      end
      unique case (state_ff)
         ST_CHECK: begin
            x0_ff    <= x0_c;
            x1_ff    <= x0_c + COORD_W'(sw_ff);
            y0_ff    <= y0_c;
            y1_ff    <= y0_c + COORD_W'(sh_ff);
            area_ff  <= area_full[DEN_W-1:0];
            total_ff <= '0;
            bad_ff   <= 1'b0;
            pix_ff   <= '0;
            err_ff   <= ERR_RANGE;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (sel_ff)
                  SEL_XLO: sx_lo_ff <= div_rsp.quot[DIM_W-1:0];
                  SEL_XHI: sx_hi_ff <= xhi_c;
                  SEL_YLO: sy_ff    <= div_rsp.quot[DIM_W-1:0];
                  SEL_YHI: sy_hi_ff <= yhi_c;
                  default: begin
                     pix_ff <= div_rsp.quot[VAL_W-1:0];
                     err_ff <= ERR_OK;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            ys_ff  <= ys_c;
            row_ff <= row_full[ADDR_W-1:0];
            xs0_ff <= xs0_c;
         end
         ST_ROW: begin
            wy_ff <= overlap(y0_ff, y1_ff, ys_ff, ys_ff + COORD_W'(dh_ff));
            sx_ff <= sx_lo_ff;
            xs_ff <= xs0_ff;
         end
         ST_READ: begin
            wx_ff <= overlap(x0_ff, x1_ff, xs_ff, xs_ff + COORD_W'(dw_ff));
         end
         ST_WEIGHT: begin
            w_ff <= {{DIM_W{1'b0}}, wx_ff} * {{DIM_W{1'b0}}, wy_ff};
         end
         ST_ACCUM: begin
            total_ff <= total_ff + prod[NUM_W-1:0];
            bad_ff   <= bad_ff || sample_bad;
            if (!last_x) begin
               sx_ff <= sx_next;
               xs_ff <= xs_ff + COORD_W'(dw_ff);
            end else if (!last_y) begin
               sy_ff  <= sy_next;
               ys_ff  <= ys_ff + COORD_W'(dh_ff);
               row_ff <= row_ff + ADDR_W'(sw_ff);
            end else if (bad_ff || sample_bad) begin
               pix_ff <= '0;
               err_ff <= ERR_SAMPLE;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pix_ff;
   assign rsp_error_code  = rsp_err_ff;

endmodule
`default_nettype wire
